// ===== hw/rtl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg: shared definitions of the page reversing scrambler
// Page size, counter widths, request codes and the pull stage record.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int PAGE_BYTES = 256;
    localparam int ADDR_W     = $clog2(PAGE_BYTES);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int PAGE_W     = 3;
    localparam int DATA_W     = 8;

    // Request codes carried in bit 0 of s_tuser.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    // Control that travels with a pull from the read stage to the output register.
    typedef struct packed {
        logic not_ready;
        logic clear;
        logic last;
    } pull_ctl_t;

endpackage

// ===== hw/rtl/page_reverse_xor_scrambler.sv =====
// ----------------------------------------------------------------------------
// page_reverse_xor_scrambler
// Loads a page of plain bytes, stores it reversed and returns it scrambled.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                  | tuser                      | tlast
//  --------+-----+------------------------+----------------------------+-------------
//  s_      | in  | [7:0] data_byte        | [0] func, [1] new_image    | unused
//  m_      | out | [7:0] out_byte         | [0] not_ready              | last_of_page
//
// One request is taken per cycle while the output side keeps up; a pull
// passes through the registered read of the page memory and then the output
// register before its byte is returned.
// Reset (aresetn low, synchronous) clears the counters, the page number and
// both valid flags; the page memory keeps its contents.
// A stall on m_tready holds the output register; one further pull may wait
// in the read stage before s_tready falls.
//
module page_reverse_xor_scrambler
    import prs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0]        s_tuser,   // [0] func, [1] new_image
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tuser,   // [0] not_ready
    output logic              m_tlast
);

    // The page memory holds the plain bytes already reversed, so that output
    // position b reads entry b and its partner directly.
    logic [DATA_W-1:0] page_mem [PAGE_BYTES];

    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [CNT_W-1:0]  emit_count_reg, emit_count_next;
    logic [PAGE_W-1:0] page_num_reg, page_num_next;

    logic              pull_valid_reg;
    pull_ctl_t         pull_ctl_reg, pull_ctl_next;
    logic [DATA_W-1:0] rd_a_reg, rd_b_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_nr_reg;

    logic              accept;
    logic              is_pull;
    logic              page_full;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
    logic [CNT_W-1:0]  k_val;
    logic [CNT_W-1:0]  pivot;
    logic [CNT_W-1:0]  emit_inc;
    logic              pipe_move;
    logic [DATA_W-1:0] pull_byte;

    // The read stage drains whenever the output register is empty or being taken.
    assign pipe_move = pull_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !pull_valid_reg || !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_pull   = (s_tuser[0] == FUNC_PULL);
    assign page_full = (load_count_reg == CNT_W'(PAGE_BYTES));

    // Scramble geometry: k is the page number plus one, pivot the byte sent in the clear.
    assign k_val    = CNT_W'(page_num_reg) + CNT_W'(1);
    assign pivot    = CNT_W'(PAGE_BYTES) - k_val;
    assign emit_inc = emit_count_reg + CNT_W'(1);

    // Below the pivot the pair is (b, b+k); at and above it the pivot entry is
    // the first operand and b the second.
    always_comb begin
        if (emit_count_reg <= pivot) begin
            rd_a_addr = emit_count_reg[ADDR_W-1:0];
        end else begin
            rd_a_addr = pivot[ADDR_W-1:0];
        end
        if (emit_count_reg < pivot) begin
            rd_b_addr = ADDR_W'(emit_count_reg + k_val);
        end else begin
            rd_b_addr = emit_count_reg[ADDR_W-1:0];
        end
    end

    // Loads are only written while the page is not full and pulls only use data read from a
    // full page, so a read never meets a write to the same entry in one cycle.
    assign wr_en   = accept && !is_pull && !page_full;
    assign wr_addr = ADDR_W'(CNT_W'(PAGE_BYTES - 1) - load_count_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            page_mem[wr_addr] <= s_tdata;
        end
        if (accept && is_pull) begin
            rd_a_reg <= page_mem[rd_a_addr];
            rd_b_reg <= page_mem[rd_b_addr];
        end
    end

    always_comb begin
        load_count_next = load_count_reg;
        emit_count_next = emit_count_reg;
        page_num_next   = page_num_reg;
        pull_ctl_next   = '{not_ready: 1'b1, clear: 1'b0, last: 1'b0};
        if (accept) begin
            if (!is_pull) begin
                if (!page_full) begin
                    if (s_tuser[1]) begin
                        page_num_next = '0;
                    end
                    load_count_next = load_count_reg + CNT_W'(1);
                end
            end else if (page_full) begin
                pull_ctl_next.not_ready = 1'b0;
                pull_ctl_next.clear     = (emit_count_reg == pivot);
                if (emit_inc == CNT_W'(PAGE_BYTES)) begin
                    pull_ctl_next.last = 1'b1;
                    emit_count_next    = '0;
                    load_count_next    = '0;
                    page_num_next      = page_num_reg + PAGE_W'(1);
                end else begin
                    emit_count_next = emit_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            emit_count_reg <= '0;
            page_num_reg   <= '0;
            pull_valid_reg <= 1'b0;
        end else begin
            load_count_reg <= load_count_next;
            emit_count_reg <= emit_count_next;
            page_num_reg   <= page_num_next;
            if (accept && is_pull) begin
                pull_valid_reg <= 1'b1;
            end else if (pipe_move) begin
                pull_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_pull) begin
            pull_ctl_reg <= pull_ctl_next;
        end
    end

    // Combine the two operands, pass the pivot byte alone, or give zero for a refused pull.
    always_comb begin
        if (pull_ctl_reg.not_ready) begin
            pull_byte = '0;
        end else if (pull_ctl_reg.clear) begin
            pull_byte = rd_a_reg;
        end else begin
            pull_byte = rd_a_reg ^ rd_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_move) begin
            out_byte_reg <= pull_byte;
            out_last_reg <= pull_ctl_reg.last;
            out_nr_reg   <= pull_ctl_reg.not_ready;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_nr_reg;

endmodule

// ===== hw/rtl/prs_checker.sv =====
// ----------------------------------------------------------------------------
// prs_checker: port level checks of the page reversing scrambler
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module prs_checker
    import prs_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [1:0]        s_tuser,   // [0] func, [1] new_image
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,   // [7:0] out_byte
    input logic              m_tuser,   // [0] not_ready
    input logic              m_tlast
);

    // A refused pull carries a zero byte and never closes a page.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("refused pull carries data or end of page");

    // Every accepted pull has a result on show after the read and output registers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == FUNC_PULL) |=> ##1 m_tvalid)
        else $error("pull request produced no result");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind page_reverse_xor_scrambler prs_checker u_prs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/page_reverse_xor_scrambler_test.sv =====
// ----------------------------------------------------------------------------
// page_reverse_xor_scrambler_test: self-checking bench for the page scrambler
// Drives load and pull requests over the s_ stream with bursty timing,
// predicts each scrambled byte from a behavioural copy of the page store and
// checks every m_ beat against it while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module page_reverse_xor_scrambler_test;
    import prs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT    = 600000;  // cycles before the run is declared hung
    localparam int RANDOM_FLOOR = 1550;    // random requests sent after the directed rows
    localparam int HOLD_AT      = 300;     // result count that triggers the long stall
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 1000;    // random request count where the sender drains
    localparam int TAIL_CYCLES  = 8;

    // One request as the sender sees it, and one result beat.
    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] data;
        logic              new_image;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              last;
        logic              not_ready;
    } res_t;

    typedef struct {
        req_t req;
        bit   typed;
        res_t want;
    } row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    // A pull that arrives before the page is full always looks like this.
    localparam res_t PULL_TOO_EARLY = '{8'h00, 1'b0, 1'b1};
    localparam res_t NO_RESULT      = '{8'h00, 1'b0, 1'b0};

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // [7:0] data_byte
    logic [1:0]        s_tuser  = '0;   // [0] func, [1] new_image
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // [7:0] out_byte
    logic              m_tuser;         // [0] not_ready
    logic              m_tlast;

    page_reverse_xor_scrambler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioural copy of the block. The page is held already reversed, so
    // entry i is the i-th byte counted from the end of the plain page.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] page_copy [PAGE_BYTES];
    logic [CNT_W-1:0]  fill_count  = '0;
    logic [CNT_W-1:0]  drain_count = '0;
    logic [PAGE_W-1:0] page_index  = '0;

    res_t expected_bytes [$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;

    // Applies one accepted request to the copy; returns 1 when it yields a beat.
    function automatic bit scramble_step(input req_t r, output res_t res);
        int unsigned k;
        int unsigned pivot;
        int unsigned b;
        res = NO_RESULT;
        if (r.func == FUNC_LOAD) begin
            // A full page is still draining, so the load vanishes, flag and all.
            if (fill_count >= PAGE_BYTES) return 1'b0;
            if (r.new_image) page_index = '0;
            page_copy[PAGE_BYTES - 1 - fill_count] = r.data;
            fill_count++;
            return 1'b0;
        end
        if (fill_count < PAGE_BYTES) begin
            res = PULL_TOO_EARLY;
            return 1'b1;
        end
        k     = int'(page_index) + 1;
        pivot = PAGE_BYTES - k;
        b     = drain_count;
        if (b < pivot) res.out_byte = page_copy[b] ^ page_copy[b + k];
        else if (b == pivot) res.out_byte = page_copy[pivot];
        else res.out_byte = page_copy[pivot] ^ page_copy[b];
        drain_count++;
        if (drain_count >= PAGE_BYTES) begin
            res.last = 1'b1;
            drain_count = '0;
            fill_count  = '0;
            page_index  = page_index + 1'b1;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Requests go out in bursts; between most bursts tvalid drops for a
    // random gap. A request is taken at the edge where tvalid and tready are
    // both high, and the expected beat is queued at that same edge.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic offer(input req_t r, input bit typed, input res_t want);
        int unsigned gap;
        res_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= r.data;
        s_tuser  <= {r.new_image, r.func};
        do @(posedge aclk); while (!s_tready);
        if (scramble_step(r, predicted))
            expected_bytes.push_back(typed ? want : predicted);
    endtask

    // Directed opening: pulls against an empty or partly filled page, data
    // extremes and the restart flag while the page number is still zero.
    row_t directed_rows [12] = '{
        '{'{FUNC_PULL, 8'hff, 1'b1}, 1'b1, PULL_TOO_EARLY},
        '{'{FUNC_LOAD, 8'h00, 1'b1}, 1'b0, NO_RESULT},
        '{'{FUNC_LOAD, 8'hff, 1'b0}, 1'b0, NO_RESULT},
        '{'{FUNC_PULL, 8'h00, 1'b0}, 1'b1, PULL_TOO_EARLY},
        '{'{FUNC_LOAD, 8'h80, 1'b0}, 1'b0, NO_RESULT},
        '{'{FUNC_LOAD, 8'h01, 1'b1}, 1'b0, NO_RESULT},
        '{'{FUNC_LOAD, 8'h7f, 1'b0}, 1'b0, NO_RESULT},
        '{'{FUNC_LOAD, 8'hfe, 1'b0}, 1'b0, NO_RESULT},
        '{'{FUNC_PULL, 8'h55, 1'b1}, 1'b1, PULL_TOO_EARLY},
        '{'{FUNC_LOAD, 8'haa, 1'b0}, 1'b0, NO_RESULT},
        '{'{FUNC_LOAD, 8'h55, 1'b0}, 1'b0, NO_RESULT},
        '{'{FUNC_PULL, 8'haa, 1'b0}, 1'b1, PULL_TOO_EARLY}
    };

    initial begin
        req_t        r;
        int unsigned random_count;
        bit          filling;
        random_count = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Random part: mostly well-formed pages (fill, then drain) with random
        // bytes, salted with pulls while filling and loads while draining.
        while (random_count < RANDOM_FLOOR) begin
            filling     = (fill_count < PAGE_BYTES);
            r.data      = DATA_W'($urandom_range(0, 255));
            r.new_image = 1'b0;
            if ($urandom_range(0, 15) == 0) begin
                // Stray request: a pull that comes too early or a load that is dropped.
                r.func      = filling ? FUNC_PULL : FUNC_LOAD;
                r.new_image = 1'($urandom_range(0, 1));
            end else begin
                r.func = filling ? FUNC_LOAD : FUNC_PULL;
                if (filling) begin
                    // An occasional restart mid-image pulls a non-zero page
                    // number back to zero.
                    if (page_index != '0)
                        r.new_image = ($urandom_range(0, 63) == 0);
                end else begin
                    r.new_image = 1'($urandom_range(0, 1));
                end
            end
            offer(r, 1'b0, NO_RESULT);
            random_count++;

            // Let the block run completely dry once before carrying on.
            if (random_count == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                burst_left = 0;
                do @(posedge aclk); while (expected_bytes.size() != 0);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_bytes.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. tready follows one of three modes chosen per stretch: always
    // open, a random bit pattern, or mostly closed. Once, after a few hundred
    // beats, it closes for a long spell so the pipeline backs up into s_tready.
    // ------------------------------------------------------------------------
    initial begin
        rx_mode_t    mode;
        int unsigned stretch_left;
        logic [31:0] pattern;
        bit          held;
        mode         = RX_OPEN;
        stretch_left = 0;
        pattern      = '0;
        held         = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (stretch_left == 0) begin
                mode         = rx_mode_t'($urandom_range(0, 2));
                stretch_left = $urandom_range(16, 96);
                pattern      = $urandom;
            end
            stretch_left--;
            case (mode)
                RX_OPEN: begin
                    m_tready <= 1'b1;
                end
                RX_PATTERN: begin
                    m_tready <= pattern[stretch_left % 32];
                end
                default: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Checker. Every beat taken on m_ is compared field by field with the
    // oldest expectation; only the first few mismatches are printed.
    // ------------------------------------------------------------------------
    function automatic void report_mismatch(input string what, input res_t want,
                                            input res_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s) at beat %0d: expected byte %02h last %0b ",
                      "not_ready %0b, got byte %02h last %0b not_ready %0b"},
                     what, results_seen, want.out_byte, want.last, want.not_ready,
                     got.out_byte, got.last, got.not_ready);
    endfunction

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tlast, m_tuser};
            results_seen++;
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected beat", NO_RESULT, got);
            end else begin
                want = expected_bytes.pop_front();
                if (got.out_byte !== want.out_byte) report_mismatch("out_byte", want, got);
                if (got.last !== want.last) report_mismatch("last_of_page", want, got);
                if (got.not_ready !== want.not_ready) report_mismatch("not_ready", want, got);
            end
        end
    end

    // Watchdog: a run that has not finished by now has hung.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
